FILE: design/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types and constants for the RESP command array parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rap_pkg;

    localparam int MAX_ARGS_DEF = 1024;
    localparam int LEN_BITS_DEF = 32;

    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        logic sign;
        logic digits;
        logic lzero;
    } num_flags_t;

    typedef struct packed {
        logic        valid;
        logic        data_valid;
        logic [7:0]  out_byte;
        logic [9:0]  arg_index;
        logic        arg_end;
        logic        done_res;
        logic        status;
        logic [10:0] arg_count;
    } result_t;

endpackage

`default_nettype wire

FILE: design/resp_array_parser_unit.sv
// An accepted byte beat passes the input register and then the result register.
// One byte per cycle while the result register can load; the parser state
// updates in a single pass between the input register and the result register.
// Bytes that produce no result are absorbed without an output beat.
// Reset clears the parser to expect an array marker; it returns there after
// every byte marked last.
// ----------------------------------------------------------------------------
// resp_array_parser_unit
// Streaming RESP command array parser with payload byte and status output.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_array_parser_unit #(
    parameter int MAX_ARGS = rap_pkg::MAX_ARGS_DEF,
    parameter int LEN_BITS = rap_pkg::LEN_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic             data_valid,
    output logic [7:0]       out_byte,
    output logic [9:0]       arg_index,
    output logic             arg_end,
    output logic             done_res,
    output logic             status,
    output logic [10:0]      arg_count
);

    logic             s1_vld_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;
    logic             out_vld_reg;
    rap_pkg::result_t out_reg;
    rap_pkg::result_t res;
    logic             adv;
    logic             step;

    // The result register can load when it is empty or being drained.
    assign adv        = !out_vld_reg || res_ready;
    assign step       = s1_vld_reg && adv;
    assign byte_ready = !s1_vld_reg || adv;

    rap_ctrl #(
        .MAX_ARGS (MAX_ARGS),
        .LEN_BITS (LEN_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .ch    (s1_byte_reg),
        .last  (s1_last_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
            begin
                s1_vld_reg <= byte_valid;
            end
            if (adv)
            begin
                out_vld_reg <= step && res.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    assign res_valid  = out_vld_reg;
    assign data_valid = out_reg.data_valid;
    assign out_byte   = out_reg.out_byte;
    assign arg_index  = out_reg.arg_index;
    assign arg_end    = out_reg.arg_end;
    assign done_res   = out_reg.done_res;
    assign status     = out_reg.status;
    assign arg_count  = out_reg.arg_count;

endmodule

`default_nettype wire

FILE: design/rap_digit.sv
// ----------------------------------------------------------------------------
// rap_digit
// Takes one character of a count or length field and updates the decimal
// accumulator, the field flags and the error indication.
// ----------------------------------------------------------------------------
`default_nettype none

module rap_digit #(
    parameter int MAX_ARGS = rap_pkg::MAX_ARGS_DEF,
    parameter int LEN_BITS = rap_pkg::LEN_BITS_DEF,
    parameter int ACC_W    = LEN_BITS
) (
    input  wire logic [7:0]         ch,
    input  wire logic               is_count,
    input  wire rap_pkg::num_flags_t flags,
    input  wire logic [ACC_W-1:0]   acc,
    output rap_pkg::num_flags_t     flags_next,
    output logic [ACC_W-1:0]        acc_next,
    output logic                    err
);

    localparam int PW = ACC_W + 4;
    localparam logic [PW-1:0] CNT_LIM = PW'(MAX_ARGS);
    localparam logic [PW-1:0] LEN_LIM = PW'((64'd1 << LEN_BITS) - 64'd1);

    logic [PW-1:0] prod;
    logic [PW-1:0] lim;
    logic          is_digit;

    // Ten times the accumulator plus the new digit, built from two shifts.
    assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                  + PW'(ch - rap_pkg::CH_ZERO);
    assign lim      = is_count ? CNT_LIM : LEN_LIM;
    assign is_digit = (ch >= rap_pkg::CH_ZERO) && (ch <= rap_pkg::CH_NINE);

    always_comb
    begin
        flags_next = flags;
        acc_next   = acc;
        err        = 1'b0;
        priority if (ch == rap_pkg::CH_MINUS && flags == '0)
        begin
            flags_next.sign = 1'b1;
        end
        else if (!is_digit || flags.lzero)
        begin
            err = 1'b1;
        end
        else if (ch == rap_pkg::CH_ZERO && !flags.digits)
        begin
            // A leading zero must be the whole number and cannot follow a minus.
            err               = flags.sign;
            flags_next.digits = 1'b1;
            flags_next.lzero  = 1'b1;
        end
        else
        begin
            flags_next.digits = 1'b1;
            acc_next          = prod[ACC_W-1:0];
            err               = (prod > lim);
        end
    end

endmodule

`default_nettype wire

FILE: design/rap_ctrl.sv
// ----------------------------------------------------------------------------
// rap_ctrl
// Parser state and the single-pass next-state and result logic for one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rap_ctrl #(
    parameter int MAX_ARGS = rap_pkg::MAX_ARGS_DEF,
    parameter int LEN_BITS = rap_pkg::LEN_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      ch,
    input  wire logic            last,
    output rap_pkg::result_t     res
);

    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int ACC_W = (LEN_BITS > CNT_W) ? LEN_BITS : CNT_W;

    typedef enum logic [2:0] {
        PH_ARRAY_MARK,
        PH_COUNT_NUM,
        PH_ELEM_MARK,
        PH_LEN_NUM,
        PH_PAYLOAD,
        PH_TRAIL1,
        PH_TRAIL2,
        PH_COMPLETE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    rap_pkg::num_flags_t flags_reg, flags_next;
    logic [7:0]          held_reg, held_next;
    logic                held_vld_reg, held_vld_next;
    logic [CNT_W-1:0]    elem_left_reg, elem_left_next;
    logic [LEN_BITS-1:0] pay_left_reg, pay_left_next;
    logic [9:0]          cur_arg_reg, cur_arg_next;
    logic [CNT_W-1:0]    decl_reg, decl_next;
    logic                err_reg, err_next;

    rap_pkg::num_flags_t dg_flags;
    logic [ACC_W-1:0]    dg_acc;
    logic                dg_err;
    logic [CNT_W-1:0]    elem_dec;
    logic [CNT_W+10:0]   decl_ext;
    logic                emit;
    logic                dv;
    logic                aend;
    logic [7:0]          ob;
    logic [9:0]          idx;

    rap_digit #(
        .MAX_ARGS (MAX_ARGS),
        .LEN_BITS (LEN_BITS),
        .ACC_W    (ACC_W)
    ) u_digit (
        .ch         (held_reg),
        .is_count   (phase_reg == PH_COUNT_NUM),
        .flags      (flags_reg),
        .acc        (acc_reg),
        .flags_next (dg_flags),
        .acc_next   (dg_acc),
        .err        (dg_err)
    );

    assign elem_dec = (elem_left_reg != '0) ? elem_left_reg - 1'b1 : elem_left_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        flags_next     = flags_reg;
        held_next      = held_reg;
        held_vld_next  = held_vld_reg;
        elem_left_next = elem_left_reg;
        pay_left_next  = pay_left_reg;
        cur_arg_next   = cur_arg_reg;
        decl_next      = decl_reg;
        err_next       = err_reg;
        emit           = 1'b0;
        dv             = 1'b0;
        aend           = 1'b0;
        ob             = 8'h00;
        idx            = 10'd0;

        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_ARRAY_MARK, PH_ELEM_MARK:
                begin
                    if (ch == ((phase_reg == PH_ARRAY_MARK) ? rap_pkg::CH_STAR
                                                             : rap_pkg::CH_DOLLAR))
                    begin
                        phase_next    = (phase_reg == PH_ARRAY_MARK) ? PH_COUNT_NUM
                                                                      : PH_LEN_NUM;
                        acc_next      = '0;
                        flags_next    = '0;
                        held_vld_next = 1'b0;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_COUNT_NUM, PH_LEN_NUM:
                begin
                    if (ch != rap_pkg::CH_NEWLINE)
                    begin
                        // The byte before the newline is held back and never parsed.
                        if (held_vld_reg)
                        begin
                            flags_next = dg_flags;
                            acc_next   = dg_acc;
                            err_next   = dg_err;
                        end
                        held_next     = ch;
                        held_vld_next = 1'b1;
                    end
                    else if (!flags_reg.digits || flags_reg.sign)
                    begin
                        err_next = 1'b1;
                    end
                    else if (phase_reg == PH_COUNT_NUM)
                    begin
                        decl_next      = acc_reg[CNT_W-1:0];
                        elem_left_next = acc_reg[CNT_W-1:0];
                        cur_arg_next   = 10'd0;
                        phase_next     = (acc_reg[CNT_W-1:0] != '0) ? PH_ELEM_MARK
                                                                    : PH_COMPLETE;
                    end
                    else
                    begin
                        pay_left_next = acc_reg[LEN_BITS-1:0];
                        if (acc_reg[LEN_BITS-1:0] == '0)
                        begin
                            // Empty argument: an end mark with no payload byte.
                            emit       = 1'b1;
                            aend       = 1'b1;
                            idx        = cur_arg_reg;
                            phase_next = PH_TRAIL1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    emit          = 1'b1;
                    dv            = 1'b1;
                    ob            = ch;
                    idx           = cur_arg_reg;
                    aend          = (pay_left_reg == LEN_BITS'(1));
                    pay_left_next = pay_left_reg - 1'b1;
                    if (pay_left_reg == LEN_BITS'(1))
                    begin
                        phase_next = PH_TRAIL1;
                    end
                end
                PH_TRAIL1:
                begin
                    phase_next = PH_TRAIL2;
                end
                PH_TRAIL2:
                begin
                    cur_arg_next   = cur_arg_reg + 1'b1;
                    elem_left_next = elem_dec;
                    phase_next     = (elem_dec != '0) ? PH_ELEM_MARK : PH_COMPLETE;
                end
                PH_COMPLETE:
                begin
                    err_next = 1'b1;
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end

        decl_ext = (CNT_W + 11)'(decl_next);

        res            = '0;
        res.valid      = emit || last;
        res.data_valid = dv;
        res.out_byte   = ob;
        res.arg_index  = idx;
        res.arg_end    = aend;
        if (last)
        begin
            res.done_res  = 1'b1;
            res.status    = err_next || (phase_next != PH_COMPLETE);
            res.arg_count = decl_ext[10:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ARRAY_MARK;
            acc_reg       <= '0;
            flags_reg     <= '0;
            held_reg      <= '0;
            held_vld_reg  <= 1'b0;
            elem_left_reg <= '0;
            pay_left_reg  <= '0;
            cur_arg_reg   <= '0;
            decl_reg      <= '0;
            err_reg       <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                // The message is finished: start over for the next one.
                phase_reg     <= PH_ARRAY_MARK;
                acc_reg       <= '0;
                flags_reg     <= '0;
                held_reg      <= '0;
                held_vld_reg  <= 1'b0;
                elem_left_reg <= '0;
                pay_left_reg  <= '0;
                cur_arg_reg   <= '0;
                decl_reg      <= '0;
                err_reg       <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                acc_reg       <= acc_next;
                flags_reg     <= flags_next;
                held_reg      <= held_next;
                held_vld_reg  <= held_vld_next;
                elem_left_reg <= elem_left_next;
                pay_left_reg  <= pay_left_next;
                cur_arg_reg   <= cur_arg_next;
                decl_reg      <= decl_next;
                err_reg       <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/rap_tb_pkg.sv
// ----------------------------------------------------------------------------
// rap_tb_pkg
// Parse tracker for the RESP array parser bench: it follows the byte stream
// the same way the parser must, keeps the result beats that are still owed
// and compares each observed result beat against the oldest one.
// ----------------------------------------------------------------------------
package rap_tb_pkg;

    typedef logic [7:0] byte_q_t[$];

    typedef enum logic [2:0] {
        ST_WAIT_STAR,
        ST_COUNT,
        ST_WAIT_DOLLAR,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_TRAIL_A,
        ST_TRAIL_B,
        ST_DONE
    } parse_phase_t;

    class resp_parse_tracker;

        parse_phase_t        phase;
        logic [63:0]         accum;
        rap_pkg::num_flags_t flags;
        logic                held_ok;
        logic [7:0]          held;
        int unsigned         args_left;
        logic [63:0]         bytes_left;
        int unsigned         arg_no;
        int unsigned         count_seen;
        bit                  failed;

        rap_pkg::result_t    owed_beats[$];
        int                  mismatches;
        int                  live_bytes;
        int                  beats_checked;
        int                  messages;
        int                  bad_messages;

        function new();
            restart();
            mismatches    = 0;
            live_bytes    = 0;
            beats_checked = 0;
            messages      = 0;
            bad_messages  = 0;
        endfunction

        function void restart();
            phase      = ST_WAIT_STAR;
            accum      = '0;
            flags      = '0;
            held_ok    = 1'b0;
            held       = '0;
            args_left  = 0;
            bytes_left = '0;
            arg_no     = 0;
            count_seen = 0;
            failed     = 1'b0;
        endfunction

        function void clear_number();
            accum   = '0;
            flags   = '0;
            held_ok = 1'b0;
            held    = '0;
        endfunction

        // Folds one character of a number into the accumulator. The limit is the
        // argument bound for the count line and the length range otherwise.
        function void take_digit(logic [7:0] c);
            logic [63:0] bound;
            bound = (phase == ST_COUNT) ? 64'(rap_pkg::MAX_ARGS_DEF)
                                        : (64'd1 << rap_pkg::LEN_BITS_DEF) - 64'd1;
            if (c == rap_pkg::CH_MINUS && flags == '0)
            begin
                flags.sign = 1'b1;
                return;
            end
            if (c < rap_pkg::CH_ZERO || c > rap_pkg::CH_NINE || flags.lzero)
            begin
                failed = 1'b1;
                return;
            end
            if (c == rap_pkg::CH_ZERO && !flags.digits)
            begin
                if (flags.sign)
                    failed = 1'b1;
                flags.digits = 1'b1;
                flags.lzero  = 1'b1;
                return;
            end
            flags.digits = 1'b1;
            accum = accum * 64'd10 + 64'(c - rap_pkg::CH_ZERO);
            if (accum > bound)
                failed = 1'b1;
        endfunction

        // Advances the parse by one byte; returns 1 when the byte owes a result beat.
        function bit parse_byte(logic [7:0] b, logic last, output rap_pkg::result_t r);
            bit emit;
            r    = '0;
            emit = 1'b0;
            if (!failed)
            begin
                case (phase)
                    ST_WAIT_STAR, ST_WAIT_DOLLAR:
                    begin
                        if (b == ((phase == ST_WAIT_STAR) ? rap_pkg::CH_STAR
                                                          : rap_pkg::CH_DOLLAR))
                        begin
                            phase = (phase == ST_WAIT_STAR) ? ST_COUNT : ST_LENGTH;
                            clear_number();
                        end
                        else
                            failed = 1'b1;
                    end
                    ST_COUNT, ST_LENGTH:
                    begin
                        // The byte in front of the newline is held back and never parsed.
                        if (b != rap_pkg::CH_NEWLINE)
                        begin
                            if (held_ok)
                                take_digit(held);
                            held_ok = 1'b1;
                            held    = b;
                        end
                        else if (!flags.digits || flags.sign)
                            failed = 1'b1;
                        else if (phase == ST_COUNT)
                        begin
                            count_seen = accum[31:0];
                            args_left  = count_seen;
                            arg_no     = 0;
                            phase      = (args_left != 0) ? ST_WAIT_DOLLAR : ST_DONE;
                        end
                        else
                        begin
                            bytes_left = accum;
                            if (bytes_left == 0)
                            begin
                                emit        = 1'b1;
                                r.arg_end   = 1'b1;
                                r.arg_index = 10'(arg_no);
                                phase       = ST_TRAIL_A;
                            end
                            else
                                phase = ST_PAYLOAD;
                        end
                    end
                    ST_PAYLOAD:
                    begin
                        emit         = 1'b1;
                        r.data_valid = 1'b1;
                        r.out_byte   = b;
                        r.arg_index  = 10'(arg_no);
                        r.arg_end    = (bytes_left == 1);
                        bytes_left   = bytes_left - 1;
                        if (bytes_left == 0)
                            phase = ST_TRAIL_A;
                    end
                    ST_TRAIL_A:
                        phase = ST_TRAIL_B;
                    ST_TRAIL_B:
                    begin
                        arg_no++;
                        if (args_left != 0)
                            args_left--;
                        phase = (args_left != 0) ? ST_WAIT_DOLLAR : ST_DONE;
                    end
                    default:
                        failed = 1'b1;
                endcase
            end
            if (last)
            begin
                r.done_res  = 1'b1;
                r.status    = failed || (phase != ST_DONE);
                r.arg_count = 11'(count_seen);
            end
            r.valid = 1'b1;
            return emit || last;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            rap_pkg::result_t r;
            if (!failed)
                live_bytes++;
            if (parse_byte(b, last, r))
                owed_beats.push_back(r);
            if (last)
            begin
                messages++;
                if (r.status)
                    bad_messages++;
                restart();
            end
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_beat(rap_pkg::result_t got);
            rap_pkg::result_t want;
            if (owed_beats.size() == 0)
            begin
                $error("result beat with nothing expected: byte %0d index %0d done %0d",
                       got.out_byte, got.arg_index, got.done_res);
                mismatches++;
                return;
            end
            want = owed_beats.pop_front();
            beats_checked++;
            match_field("data_valid", want.data_valid, got.data_valid);
            match_field("out_byte", want.out_byte, got.out_byte);
            match_field("arg_index", want.arg_index, got.arg_index);
            match_field("arg_end", want.arg_end, got.arg_end);
            match_field("done_res", want.done_res, got.done_res);
            match_field("status", want.status, got.status);
            match_field("arg_count", want.arg_count, got.arg_count);
        endfunction

    endclass

endpackage

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives RESP command arrays, well formed and broken, byte by byte into the
// parser under random idling on both sides and a long output hold-off, and
// checks every payload and status beat against a tracker of the parse.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  in_byte    = '0;
    logic        in_last    = 1'b0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    logic        data_valid;
    logic [7:0]  out_byte;
    logic [9:0]  arg_index;
    logic        arg_end;
    logic        done_res;
    logic        status;
    logic [10:0] arg_count;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    rap_tb_pkg::resp_parse_tracker book;

    resp_array_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .data_valid (data_valid),
        .out_byte   (out_byte),
        .arg_index  (arg_index),
        .arg_end    (arg_end),
        .done_res   (done_res),
        .status     (status),
        .arg_count  (arg_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(4_000_000);
        $display("[resp_array_parser_unit] ERROR");
        $finish;
    end

    // Result side: random back-pressure, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // The input beat is noted before the result beat so that a same-edge
    // result always finds its expectation queued.
    always @(posedge clk)
    begin : watch
        rap_pkg::result_t seen;
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                book.note_byte(in_byte, in_last);
            if (res_valid && res_ready)
            begin
                seen = {1'b1, data_valid, out_byte, arg_index, arg_end,
                        done_res, status, arg_count};
                book.check_beat(seen);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic final_beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        in_byte    <= value;
        in_last    <= final_beat;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
    endtask

    task automatic send_message(input rap_tb_pkg::byte_q_t body);
        foreach (body[i])
            send_byte(body[i], i == body.size() - 1);
    endtask

    function automatic void add_text(inout rap_tb_pkg::byte_q_t q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(8'(s[i]));
    endfunction

    // Marker, number text, one dropped byte (usually a carriage return), newline.
    function automatic void put_line(inout rap_tb_pkg::byte_q_t q,
                                     input logic [7:0] marker, input string text);
        logic [7:0] dropped;
        dropped = 8'h0D;
        if ($urandom_range(9) == 0)
            dropped = 8'($urandom_range(255));
        if (dropped == rap_pkg::CH_NEWLINE)
            dropped = 8'h0D;
        q.push_back(marker);
        add_text(q, text);
        q.push_back(dropped);
        q.push_back(rap_pkg::CH_NEWLINE);
    endfunction

    function automatic string odd_number();
        case ($urandom_range(7))
            0: return "-0";
            1: return $sformatf("-%0d", $urandom_range(1, 99));
            2: return $sformatf("0%0d", $urandom_range(9));
            3: return "";
            4: return "4294967296";
            5: return "1025";
            6: return "1-2";
            default: return "9x";
        endcase
    endfunction

    // bad_line picks the number line to spoil: 0 is the count, k the length of
    // argument k-1, and a negative value keeps the command well formed.
    function automatic rap_tb_pkg::byte_q_t make_command(int nargs, int min_len,
                                                         int max_len, int bad_line);
        rap_tb_pkg::byte_q_t q;
        int                  len;
        int                  k;
        q = {};
        put_line(q, rap_pkg::CH_STAR,
                 (bad_line == 0) ? odd_number() : $sformatf("%0d", nargs));
        for (k = 0; k < nargs; k++)
        begin
            len = $urandom_range(min_len, max_len);
            put_line(q, rap_pkg::CH_DOLLAR,
                     (bad_line == k + 1) ? odd_number() : $sformatf("%0d", len));
            repeat (len)
                q.push_back(8'($urandom_range(255)));
            if ($urandom_range(7) == 0)
            begin
                q.push_back(8'($urandom_range(255)));
                q.push_back(8'($urandom_range(255)));
            end
            else
            begin
                q.push_back(8'h0D);
                q.push_back(rap_pkg::CH_NEWLINE);
            end
        end
        return q;
    endfunction

    task automatic run_directed();
        rap_tb_pkg::byte_q_t q;
        string               cases[$];
        q = {};
        add_text(q, "*2;\n$2;\n");
        q.push_back(8'h00);
        q.push_back(8'hFF);
        add_text(q, ";;$0;\n;;");
        send_message(q);
        cases = '{"*1;\n$3;\nabc;;", "*0;\n", "*-1;\n", "*-0;\n", "*01;\n", "*1-;\n",
                  "*;\n", "*5\n", "*-;\n", "*a;\n", "*1025;\n", "*1024;\n",
                  "*1;\n$4294967296;\n", "*1;\n$-3;\n", "*1;\n$4294967295;\nab",
                  "*1;\n$3;\nabc", "x1;\n", "*1;\n#3;\n", "*2;\n$1;\nq;;%",
                  "*0;\n!", "*"};
        foreach (cases[i])
        begin
            q = {};
            add_text(q, cases[i]);
            send_message(q);
        end
    endtask

    // Mostly well-formed commands; the rest get a corrupted byte, a cut,
    // trailing garbage or a spoiled number line.
    task automatic run_random(int target);
        rap_tb_pkg::byte_q_t q;
        int                  nargs;
        int                  pick;
        int                  cut;
        while (book.live_bytes < target)
        begin
            nargs = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 4);
            pick  = $urandom_range(99);
            q = make_command(nargs, 0, ($urandom_range(9) == 0) ? 40 : 6,
                             (pick >= 90) ? $urandom_range(nargs) : -1);
            if (pick >= 70 && pick < 77)
                q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
            else if (pick >= 77 && pick < 84)
            begin
                cut = $urandom_range(1, q.size() - 1);
                while (q.size() > cut)
                    void'(q.pop_back());
            end
            else if (pick >= 84 && pick < 90)
            begin
                repeat ($urandom_range(1, 3))
                    q.push_back(8'($urandom_range(255)));
            end
            send_message(q);
        end
    endtask

    initial
    begin
        book = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 81;
        run_directed();
        run_random(book.live_bytes + 500);

        send_idle_pct = 81;
        recv_idle_pct = 20;
        run_random(book.live_bytes + 500);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Long output stall while a payload-heavy command keeps the input busy.
        hold_req = 1'b1;
        send_message(make_command(2, 48, 60, -1));
        run_random(book.live_bytes + 400);
        byte_valid <= 1'b0;

        while (book.owed_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d commands, %0d of them malformed or cut short.",
                 book.messages, book.bad_messages);
        $display("%0d result beats compared; %0d bytes parsed ahead of any error.",
                 book.beats_checked, book.live_bytes);
        if (book.mismatches == 0 && book.owed_beats.size() == 0)
            $display("[resp_array_parser_unit] OK");
        else
            $display("[resp_array_parser_unit] ERROR");
        $finish;
    end

endmodule
